// File: rtl/bq_pkg.sv
`timescale 1ns / 1ps

package bq_pkg;

  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned DELAY_WIDTH_DEF = 48;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Coefficient register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RST = 32'sh1000_0000;

  // One step of the shared multiply/accumulate unit
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_INIT,
    STEP_MAG,
    STEP_MLO,
    STEP_MHI,
    STEP_FIN,
    STEP_ACC
  } bq_step_e;

  typedef struct packed {
    bq_step_e step;
    logic     negate;
    logic     acc_load;
  } bq_ctrl_t;

endpackage

// File: rtl/bq_if.sv
`timescale 1ns / 1ps

interface bq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bq_pkg::WORD_W-1:0]    sample_word;
  logic        [bq_pkg::CH_W-1:0]      channel;

  modport source (output valid, sample_word, channel, input ready);
  modport sink   (input valid, sample_word, channel, output ready);
endinterface

interface bq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bq_pkg::WORD_W-1:0]    filtered_word;

  modport source (output valid, filtered_word, input ready);
  modport sink   (input valid, filtered_word, output ready);
endinterface

// File: rtl/biquad_df2_multichannel_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Handshake
// in_i      in   sample_word[31:0], channel[2:0]  valid/ready
// out_o     out  filtered_word[31:0]              valid/ready
// cfg       in   cfg_idx_i, cfg_wdata_i           cfg_we_i, no stall
//
// Each item runs from transfer to the next possible transfer through one
// delay read, five products on the shared 32x32 multiplier, each in the steps
// magnitude, low limb, high limb, round/clamp and accumulate, and a final
// step to round the result and write back the delays.
// Reset clears all delays (per-channel valid bits) and loads default coefficients.
// A result held in the output register stalls only the final step.
module biquad_df2_multichannel_unit #(
  parameter int unsigned CHANNELS    = bq_pkg::CHANNELS_DEF,
  parameter int unsigned DELAY_WIDTH = bq_pkg::DELAY_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bq_in_if.sink                          in_i,
  bq_out_if.source                       out_o,
  input  logic                           cfg_we_i,
  input  logic [bq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bq_pkg::COEF_W-1:0]      cfg_wdata_i
);
  import bq_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DW = DELAY_WIDTH;

  // Product order within one item
  localparam logic [2:0] P_A1 = 3'd0;
  localparam logic [2:0] P_A2 = 3'd1;
  localparam logic [2:0] P_B0 = 3'd2;
  localparam logic [2:0] P_B1 = 3'd3;
  localparam logic [2:0] P_B2 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MAG,
    ST_MLO,
    ST_MHI,
    ST_FIN,
    ST_ACC,
    ST_OUT
  } state_e;

  state_e                    state_q;
  logic [2:0]                cnt_q;
  logic signed [DW-1:0]      x_q;
  logic [AW-1:0]             ch_q;
  logic                      ch_ok_q;
  logic signed [DW-1:0]      w1_q;
  logic signed [DW-1:0]      w2_q;
  logic signed [DW-1:0]      w_q;
  logic                      out_vld_q;
  logic [WORD_W-1:0]         out_word_q;
  logic [CHANNELS-1:0]       vld_q;

  logic signed [COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;

  logic [8:0]                ch_ext;
  logic                      ch_ok;
  logic                      in_xfer;
  logic                      out_free;
  logic                      out_load;
  logic                      wb_en;
  logic [2*DW-1:0]           rd_data;
  logic [2*DW-1:0]           wr_data;

  bq_ctrl_t                  ctrl;
  logic signed [DW-1:0]      opd;
  logic signed [COEF_W-1:0]  coef;
  logic signed [DW-1:0]      x_in;
  logic signed [DW-1:0]      acc;
  logic [24:0]               y_mag;
  logic [23:0]               q_mag;
  logic [23:0]               q_out;

  assign ch_ext   = 9'(in_i.channel);
  assign ch_ok    = ch_ext < 9'(CHANNELS);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = (state_q == ST_OUT) && out_free;
  assign wb_en    = out_load && ch_ok_q;
  assign wr_data  = {w1_q, w_q};
  assign x_in     = DW'($signed(in_i.sample_word[WORD_W-1:8])) <<< 1;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RST;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_B2:  b2_q <= cfg_wdata_i;
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Delay store: low half holds w[n-1], high half w[n-2]
  bq_ram #(
    .Width (2 * DW),
    .Depth (CHANNELS),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wb_en),
    .waddr_i (ch_q),
    .wdata_i (wr_data),
    .re_i    (in_xfer),
    .raddr_i (ch_ext[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wb_en) begin
      vld_q[ch_q] <= 1'b1;
    end
  end

  // Operand and step selection for the shared unit
  always_comb begin
    ctrl.negate   = 1'b0;
    ctrl.acc_load = (cnt_q == P_B0);
    opd           = w1_q;
    coef          = b1_q;
    unique case (cnt_q)
      P_A1: begin
        opd = w1_q; coef = a1_q; ctrl.negate = 1'b1;
      end
      P_A2: begin
        opd = w2_q; coef = a2_q; ctrl.negate = 1'b1;
      end
      P_B0: begin
        opd = acc; coef = b0_q;
      end
      P_B1: begin
        opd = w1_q; coef = b1_q;
      end
      P_B2: begin
        opd = w2_q; coef = b2_q;
      end
      default: begin
      end
    endcase
    unique case (state_q)
      ST_READ: ctrl.step = STEP_INIT;
      ST_MAG:  ctrl.step = STEP_MAG;
      ST_MLO:  ctrl.step = STEP_MLO;
      ST_MHI:  ctrl.step = STEP_MHI;
      ST_FIN:  ctrl.step = STEP_FIN;
      ST_ACC:  ctrl.step = STEP_ACC;
      default: ctrl.step = STEP_NONE;
    endcase
  end

  bq_mulq #(
    .DelayW (DW)
  ) u_mulq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .opd_i  (opd),
    .coef_i (coef),
    .init_i (x_q),
    .acc_o  (acc)
  );

  // Round half away from zero; only the low 24 bits survive
  always_comb begin
    y_mag = acc[DW-1] ? (25'd0 - acc[24:0]) : acc[24:0];
    q_mag = y_mag[24:1] + 24'(y_mag[0]);
    q_out = acc[DW-1] ? (24'd0 - q_mag) : q_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= P_A1;
      x_q        <= '0;
      ch_q       <= '0;
      ch_ok_q    <= 1'b0;
      w1_q       <= '0;
      w2_q       <= '0;
      w_q        <= '0;
      out_vld_q  <= 1'b0;
      out_word_q <= '0;
    end else begin
      // Load a new result or drop the one that just transferred
      if (out_load) begin
        out_vld_q  <= 1'b1;
        out_word_q <= {q_out, 8'h00};
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            x_q     <= x_in;
            ch_q    <= ch_ext[AW-1:0];
            ch_ok_q <= ch_ok;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          // Unwritten or out-of-range channels read as zero delays
          if (ch_ok_q && vld_q[ch_q]) begin
            w1_q <= rd_data[DW-1:0];
            w2_q <= rd_data[2*DW-1:DW];
          end else begin
            w1_q <= '0;
            w2_q <= '0;
          end
          cnt_q   <= P_A1;
          state_q <= ST_MAG;
        end
        ST_MAG: begin
          if (cnt_q == P_B0) begin
            w_q <= acc;
          end
          state_q <= ST_MLO;
        end
        ST_MLO: state_q <= ST_MHI;
        ST_MHI: state_q <= ST_FIN;
        ST_FIN: state_q <= ST_ACC;
        ST_ACC: begin
          if (cnt_q == P_B2) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= ST_MAG;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.filtered_word = out_word_q;

endmodule

// File: rtl/bq_ram.sv
`timescale 1ns / 1ps

module bq_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bq_mulq.sv
`timescale 1ns / 1ps

module bq_mulq #(
  parameter int unsigned DelayW = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bq_pkg::bq_ctrl_t                  ctrl_i,
  input  logic signed [DelayW-1:0]          opd_i,
  input  logic signed [bq_pkg::COEF_W-1:0]  coef_i,
  input  logic signed [DelayW-1:0]          init_i,
  output logic signed [DelayW-1:0]          acc_o
);
  import bq_pkg::*;

  localparam logic [DelayW-1:0] DMAX = {1'b0, {(DelayW-1){1'b1}}};
  localparam logic [DelayW-1:0] DMIN = {1'b1, {(DelayW-1){1'b0}}};

  logic [63:0]        md_q;
  logic [COEF_W-1:0]  mc_q;
  logic               neg_q;
  logic [63:0]        lo_q;
  logic [63:0]        hi_q;
  logic [35:0]        lrnd_q;
  logic [DelayW-1:0]  prod_q;
  logic [DelayW-1:0]  acc_q;

  logic [DelayW-1:0]  md_d;
  logic [COEF_W-1:0]  mc_d;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic [63:0]        lo_rnd;
  logic [67:0]        r_sum;
  logic [67:0]        r_lim;
  logic [67:0]        r_clip;
  logic [DelayW-1:0]  prod_d;
  logic [DelayW:0]    s_sum;
  logic [DelayW-1:0]  s_sat;

  always_comb begin
    md_d   = opd_i[DelayW-1] ? (DelayW'(0) - opd_i) : opd_i;
    mc_d   = coef_i[COEF_W-1] ? (COEF_W'(0) - coef_i) : coef_i;
    // one 32x32 multiplier serves both limbs
    mul_a  = (ctrl_i.step == STEP_MHI) ? md_q[63:32] : md_q[31:0];
    mul_p  = 64'(mul_a) * 64'(mc_q);
    lo_rnd = lo_q + 64'h0000_0000_0800_0000;
    // hi limb already sits 32 bits up; the 28-bit drop leaves 4
    r_sum  = {hi_q, 4'b0000} + 68'(lrnd_q);
    r_lim  = 68'(DMAX) + 68'(neg_q);
    r_clip = (r_sum > r_lim) ? r_lim : r_sum;
    prod_d = neg_q ? (DelayW'(0) - r_clip[DelayW-1:0]) : r_clip[DelayW-1:0];
    s_sum  = {acc_q[DelayW-1], acc_q} + {prod_q[DelayW-1], prod_q};
    if (s_sum[DelayW] != s_sum[DelayW-1]) begin
      s_sat = s_sum[DelayW] ? DMIN : DMAX;
    end else begin
      s_sat = s_sum[DelayW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q   <= '0;
      mc_q   <= '0;
      neg_q  <= 1'b0;
      lo_q   <= '0;
      hi_q   <= '0;
      lrnd_q <= '0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      unique case (ctrl_i.step)
        STEP_INIT: begin
          acc_q <= init_i;
        end
        STEP_MAG: begin
          md_q  <= 64'(md_d);
          mc_q  <= mc_d;
          neg_q <= opd_i[DelayW-1] ^ coef_i[COEF_W-1] ^ ctrl_i.negate;
        end
        STEP_MLO: begin
          lo_q <= mul_p;
        end
        STEP_MHI: begin
          hi_q   <= mul_p;
          lrnd_q <= lo_rnd[63:28];
        end
        STEP_FIN: begin
          prod_q <= prod_d;
        end
        STEP_ACC: begin
          acc_q <= ctrl_i.acc_load ? prod_q : s_sat;
        end
        default: begin
        end
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule
